[hw/rtl/ndef_record_header_parser_defines.svh]
// Assertion macros for the NDEF record header parser checks.
// Each expects clk and rst in the scope of its use.
`ifndef NDEF_RECORD_HEADER_PARSER_DEFINES_SVH
`define NDEF_RECORD_HEADER_PARSER_DEFINES_SVH

`define NDEFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define NDEFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ndefp_pkg.sv]
package ndefp_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = 34;
  localparam int CFG_DATA_BITS = 16;

  localparam int FLAG_SR_BIT   = 4;
  localparam int FLAG_IL_BIT   = 3;
  localparam int LONG_LEN_BYTES = 4;

  localparam logic [2:0]  TNF_WELL_KNOWN = 3'd1;
  localparam logic [7:0]  TYPE_URI       = 8'h55;
  localparam logic [7:0]  TYPE_TEXT      = 8'h54;
  localparam logic [7:0]  PREFIX_MIN     = 8'd1;
  localparam logic [7:0]  PREFIX_MAX     = 8'd6;
  localparam logic [7:0]  CHAR_LO        = 8'd32;
  localparam logic [7:0]  CHAR_HI        = 8'd126;
  localparam logic [7:0]  CHAR_DOT       = 8'h2E;
  localparam logic [7:0]  HEX_LIMIT_RST  = 8'd24;
  localparam logic [15:0] TEXT_LIMIT_RST = 16'd72;

  localparam int SHORT_HDR_BYTES = 3;
  localparam int LONG_HDR_BYTES  = 6;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [3:0] {
    PH_FLAGS   = 4'd0,
    PH_TYPELEN = 4'd1,
    PH_PAYLEN  = 4'd2,
    PH_IDLEN   = 4'd3,
    PH_TYPE    = 4'd4,
    PH_ID      = 4'd5,
    PH_URI     = 4'd6,
    PH_LANGHDR = 4'd7,
    PH_LANG    = 4'd8,
    PH_BODY    = 4'd9,
    PH_TRAIL   = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_URI   = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SHORT     = 3'd2,
    ST_TRUNC_HDR = 3'd3,
    ST_TRUNC_ID  = 3'd4,
    ST_TRUNC_REC = 3'd5
  } status_t;

  typedef enum logic {
    CFG_HEX_SHOW_LIMIT  = 1'b0,
    CFG_TEXT_SHOW_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  flag_bits;
    logic [7:0]  type_len;
    logic [7:0]  id_len;
    logic [31:0] pay_len;
  } hdr_t;

endpackage

[hw/rtl/ndefp_in_if.sv]
interface ndefp_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, has_byte, byte_value, last, input ready);
  modport sink   (input valid, has_byte, byte_value, last, output ready);
endinterface

[hw/rtl/ndefp_out_if.sv]
interface ndefp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  region;
  logic [7:0]  display_char;
  logic        shown;
  logic [1:0]  record_kind;
  logic [2:0]  uri_code;
  logic [31:0] payload_length;
  logic [2:0]  status;
  logic        end_flag;

  modport source (
    output valid, region, display_char, shown, record_kind, uri_code,
           payload_length, status, end_flag,
    input  ready
  );
  modport sink (
    input  valid, region, display_char, shown, record_kind, uri_code,
           payload_length, status, end_flag,
    output ready
  );
endinterface

[hw/rtl/ndefp_status.sv]
module ndefp_status (
  input  ndefp_pkg::hdr_t    hdr,
  input  ndefp_pkg::count_t  count,
  output ndefp_pkg::status_t status
);
  import ndefp_pkg::*;

  logic                sr;
  logic                il;
  logic [2:0]          idx;
  logic [2:0]          idx_full;
  logic [SUM_BITS-1:0] needed;

  always_comb begin
    sr       = hdr.flag_bits[FLAG_SR_BIT];
    il       = hdr.flag_bits[FLAG_IL_BIT];
    idx      = sr ? 3'(SHORT_HDR_BYTES) : 3'(LONG_HDR_BYTES);
    idx_full = il ? idx + 3'd1 : idx;
    needed   = SUM_BITS'(idx_full) + SUM_BITS'(hdr.type_len)
             + (il ? SUM_BITS'(hdr.id_len) : '0) + SUM_BITS'(hdr.pay_len);
    if (count == '0) begin
      status = ST_EMPTY;
    end else if (count < COUNT_BITS'(SHORT_HDR_BYTES)) begin
      status = ST_SHORT;
    end else if (!sr && count < COUNT_BITS'(LONG_HDR_BYTES)) begin
      status = ST_TRUNC_HDR;
    end else if (il && count <= COUNT_BITS'(idx)) begin
      status = ST_TRUNC_ID;
    end else if (needed > SUM_BITS'(count)) begin
      status = ST_TRUNC_REC;
    end else begin
      status = ST_OK;
    end
  end
endmodule

[hw/rtl/ndef_record_header_parser.sv]
// NDEF first-record header parser, one message byte per item.
// An accepted item is loaded into the input register, and its result is then
// loaded into the result register, from which it is offered.
// Throughput: one item per cycle; a held result stalls the input register.
// Reset (rst, synchronous): parser state cleared, both pipeline registers
// emptied, hex_show_limit set to 24 and text_show_limit to 72.
module ndef_record_header_parser (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  ndefp_pkg::cfg_index_t                   cfg_index,
  input  logic [ndefp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  ndefp_in_if.sink                                inbound,
  ndefp_out_if.source                             outbound
);
  import ndefp_pkg::*;

  logic [7:0]  hex_show_limit;
  logic [15:0] text_show_limit;

  logic        in_valid_q;
  logic        has_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        advance;

  count_t      byte_count, byte_count_next;
  phase_t      phase, phase_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [7:0]  type_len, type_len_next;
  logic [7:0]  id_len, id_len_next;
  logic [31:0] pay_len, pay_len_next;
  logic [31:0] field_pos, field_pos_next;
  logic [7:0]  first_type_byte, first_type_byte_next;
  logic [5:0]  lang_len, lang_len_next;
  kind_t       kind, kind_next;
  logic [2:0]  prefix_code, prefix_code_next;

  phase_t      region_c;
  logic [7:0]  disp_c;
  logic        shown_c;
  logic        hdr_done;
  logic        type_done;
  logic        pay_start;
  logic [5:0]  lang_c;
  logic [31:0] body_start;
  logic [15:0] body_limit;
  hdr_t        hdr_c;
  status_t     status_calc;
  status_t     status_c;

  logic        out_valid;

  assign advance       = in_valid_q && (!out_valid || outbound.ready);
  assign inbound.ready = !in_valid_q || advance;

  always_comb begin
    byte_count_next      = byte_count;
    phase_next           = phase;
    flag_bits_next       = flag_bits;
    type_len_next        = type_len;
    id_len_next          = id_len;
    pay_len_next         = pay_len;
    field_pos_next       = field_pos;
    first_type_byte_next = first_type_byte;
    lang_len_next        = lang_len;
    kind_next            = kind;
    prefix_code_next     = prefix_code;
    region_c             = PH_FLAGS;
    disp_c               = '0;
    shown_c              = 1'b0;
    hdr_done             = 1'b0;
    type_done            = 1'b0;
    pay_start            = 1'b0;
    lang_c               = byte_q[5:0];
    body_start           = '0;
    body_limit           = {8'b0, hex_show_limit};

    if (has_q) begin
      disp_c = (byte_q >= CHAR_LO && byte_q <= CHAR_HI) ? byte_q : CHAR_DOT;
      if (byte_count != '1) begin
        byte_count_next = byte_count + count_t'(1);
      end
      region_c = phase;
      case (phase)
        PH_FLAGS: begin
          flag_bits_next = byte_q;
          type_len_next  = '0;
          id_len_next    = '0;
          pay_len_next   = '0;
          phase_next     = PH_TYPELEN;
        end
        PH_TYPELEN: begin
          type_len_next  = byte_q;
          field_pos_next = '0;
          phase_next     = PH_PAYLEN;
        end
        PH_PAYLEN: begin
          if (flag_bits[FLAG_SR_BIT]) begin
            pay_len_next = {24'b0, byte_q};
            hdr_done     = 1'b1;
          end else begin
            pay_len_next   = {pay_len[23:0], byte_q};
            field_pos_next = field_pos + 32'd1;
            hdr_done       = field_pos_next >= 32'(LONG_LEN_BYTES);
          end
          if (hdr_done && flag_bits[FLAG_IL_BIT]) begin
            hdr_done   = 1'b0;
            phase_next = PH_IDLEN;
          end
        end
        PH_IDLEN: begin
          id_len_next = byte_q;
          hdr_done    = 1'b1;
        end
        PH_TYPE: begin
          shown_c = 1'b1;
          if (field_pos == '0) begin
            first_type_byte_next = byte_q;
          end
          field_pos_next = field_pos + 32'd1;
          type_done      = field_pos_next >= {24'b0, type_len};
        end
        PH_ID: begin
          field_pos_next = field_pos + 32'd1;
          pay_start      = field_pos_next >= {24'b0, id_len};
        end
        PH_URI: begin
          prefix_code_next = (byte_q >= PREFIX_MIN && byte_q <= PREFIX_MAX) ? byte_q[2:0]
                                                                            : 3'd0;
          field_pos_next   = 32'd1;
          phase_next       = (pay_len > 32'd1) ? PH_BODY : PH_TRAIL;
        end
        PH_LANGHDR: begin
          field_pos_next = 32'd1;
          if (pay_len > {26'b0, lang_c} + 32'd1) begin
            kind_next     = KIND_TEXT;
            lang_len_next = lang_c;
            phase_next    = (lang_c != '0) ? PH_LANG : PH_BODY;
          end else begin
            kind_next  = KIND_OTHER;
            region_c   = PH_BODY;
            shown_c    = hex_show_limit != '0;
            phase_next = (pay_len > 32'd1) ? PH_BODY : PH_TRAIL;
          end
        end
        PH_LANG: begin
          field_pos_next = field_pos + 32'd1;
          if (field_pos_next >= {26'b0, lang_len} + 32'd1) begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind == KIND_URI) begin
            body_start = 32'd1;
            body_limit = text_show_limit;
          end else if (kind == KIND_TEXT) begin
            body_start = {26'b0, lang_len} + 32'd1;
            body_limit = text_show_limit;
          end
          shown_c        = (field_pos - body_start) < {16'b0, body_limit};
          field_pos_next = field_pos + 32'd1;
          if (field_pos_next >= pay_len) begin
            phase_next = PH_TRAIL;
          end
        end
        default: begin
          region_c   = PH_TRAIL;
          phase_next = PH_TRAIL;
        end
      endcase
    end

    if (hdr_done) begin
      if (type_len_next != '0) begin
        field_pos_next = '0;
        phase_next     = PH_TYPE;
      end else begin
        type_done = 1'b1;
      end
    end
    if (type_done) begin
      if (id_len_next != '0) begin
        field_pos_next = '0;
        phase_next     = PH_ID;
      end else begin
        pay_start = 1'b1;
      end
    end
    if (pay_start) begin
      field_pos_next = '0;
      if (pay_len_next == '0) begin
        kind_next  = KIND_OTHER;
        phase_next = PH_TRAIL;
      end else if (flag_bits_next[2:0] == TNF_WELL_KNOWN && type_len_next == 8'd1
                   && first_type_byte_next == TYPE_URI) begin
        kind_next  = KIND_URI;
        phase_next = PH_URI;
      end else if (flag_bits_next[2:0] == TNF_WELL_KNOWN && type_len_next == 8'd1
                   && first_type_byte_next == TYPE_TEXT) begin
        phase_next = PH_LANGHDR;
      end else begin
        kind_next  = KIND_OTHER;
        phase_next = PH_BODY;
      end
    end
  end

  assign hdr_c = '{flag_bits: flag_bits_next, type_len: type_len_next,
                   id_len: id_len_next, pay_len: pay_len_next};

  ndefp_status u_status (
    .hdr    (hdr_c),
    .count  (byte_count_next),
    .status (status_calc)
  );

  assign status_c = last_q ? status_calc : ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_show_limit  <= HEX_LIMIT_RST;
      text_show_limit <= TEXT_LIMIT_RST;
      in_valid_q      <= 1'b0;
      out_valid       <= 1'b0;
      byte_count      <= '0;
      phase           <= PH_FLAGS;
      flag_bits       <= '0;
      type_len        <= '0;
      id_len          <= '0;
      pay_len         <= '0;
      field_pos       <= '0;
      first_type_byte <= '0;
      lang_len        <= '0;
      kind            <= KIND_NONE;
      prefix_code     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEX_SHOW_LIMIT:  hex_show_limit  <= cfg_data[7:0];
          CFG_TEXT_SHOW_LIMIT: text_show_limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (inbound.valid && inbound.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (outbound.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (last_q) begin
          byte_count      <= '0;
          phase           <= PH_FLAGS;
          flag_bits       <= '0;
          type_len        <= '0;
          id_len          <= '0;
          pay_len         <= '0;
          field_pos       <= '0;
          first_type_byte <= '0;
          lang_len        <= '0;
          kind            <= KIND_NONE;
          prefix_code     <= '0;
        end else begin
          byte_count      <= byte_count_next;
          phase           <= phase_next;
          flag_bits       <= flag_bits_next;
          type_len        <= type_len_next;
          id_len          <= id_len_next;
          pay_len         <= pay_len_next;
          field_pos       <= field_pos_next;
          first_type_byte <= first_type_byte_next;
          lang_len        <= lang_len_next;
          kind            <= kind_next;
          prefix_code     <= prefix_code_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inbound.valid && inbound.ready) begin
      has_q  <= inbound.has_byte;
      byte_q <= inbound.byte_value;
      last_q <= inbound.last;
    end
    if (advance) begin
      outbound.region         <= region_c;
      outbound.display_char   <= disp_c;
      outbound.shown          <= shown_c;
      outbound.record_kind    <= kind_next;
      outbound.uri_code       <= prefix_code_next;
      outbound.payload_length <= pay_len_next;
      outbound.status         <= status_c;
      outbound.end_flag       <= last_q;
    end
  end

  assign outbound.valid = out_valid;
endmodule

[hw/rtl/ndefp_checker.sv]
`include "ndef_record_header_parser_defines.svh"

module ndefp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  region,
  input logic        shown,
  input logic [31:0] payload_length,
  input logic [2:0]  status,
  input logic        end_flag
);
  import ndefp_pkg::*;

  `NDEFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(region) && $stable(status) && $stable(payload_length),
    "stalled item changed")
  `NDEFP_ASSERT_NOW(a_status_on_end, out_valid && !end_flag, status == ST_OK,
    "status reported before end of message")
  `NDEFP_ASSERT_NOW(a_trail_hidden, out_valid && region == PH_TRAIL, !shown,
    "trailing byte marked shown")
  `NDEFP_ASSERT_NOW(a_type_shown, out_valid && region == PH_TYPE, shown,
    "type byte not shown")
endmodule

bind ndef_record_header_parser ndefp_checker u_ndefp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (outbound.valid),
  .out_ready      (outbound.ready),
  .region         (outbound.region),
  .shown          (outbound.shown),
  .payload_length (outbound.payload_length),
  .status         (outbound.status),
  .end_flag       (outbound.end_flag)
);
